/* rtl/ssfr_pkg.sv */
// Shared types and constants for the serial servo frame receiver.
// No dependencies; imported by ssfr_frame_ram and serial_servo_frame_receiver.
package ssfr_pkg;

    localparam int STORE_DEPTH = 24;                        // frame bytes kept (0..23)
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CHAN_COUNT  = 16;
    localparam int CHAN_W      = 11;
    localparam int IDX_W       = $clog2(CHAN_COUNT);
    localparam int FLAGS_W     = 8;
    localparam int SIL_W       = 16;
    localparam int GAP_W       = 8;
    localparam int CFG_W       = 16;
    localparam int ACC_W       = CHAN_W + 7;                // at most 10 + 8 bits pending
    localparam int NBITS_W     = $clog2(ACC_W + 1);

    localparam logic [7:0]         HEADER_BYTE    = 8'h0f;
    localparam logic [ADDR_W-1:0]  FLAGS_POS      = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [ADDR_W-1:0]  LAST_POS       = ADDR_W'(STORE_DEPTH);   // byte 24, not kept
    localparam logic [ADDR_W-1:0]  FIRST_CHAN_POS = ADDR_W'(1);
    localparam logic [FLAGS_W-1:0] FAILSAFE_FLAGS = 8'hff;
    localparam logic [SIL_W-1:0]   SIL_MAX        = '1;
    localparam logic [GAP_W-1:0]   GAP_RESET      = 8'd1;
    localparam logic [SIL_W-1:0]   FAILSAFE_RESET = 16'd100;

    typedef enum logic [1:0] {
        MODE_BYTE  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_ERROR = 2'd2
    } mode_t;

    typedef enum logic {
        KIND_CHANNEL  = 1'b0,
        KIND_FAILSAFE = 1'b1
    } kind_t;

    typedef enum logic {
        CFG_GAP_LIMIT      = 1'b0,
        CFG_FAILSAFE_LIMIT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_ctl_t;

endpackage

/* rtl/ssfr_frame_ram.sv */
// Frame byte store: one write port, one read port, registered read data.
// Depends on ssfr_pkg.
module ssfr_frame_ram (
    input  logic             aclk,
    input  ssfr_pkg::ram_ctl_t ctl,
    output logic [7:0]       rd_data
);
    import ssfr_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rd_data_reg <= mem[ctl.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/serial_servo_frame_receiver.sv */
// Top level of the serial servo frame receiver: frame assembly, silence timing,
// channel unpacking and output register. Depends on ssfr_pkg and ssfr_frame_ram.
//
// Input items are bytes, millisecond ticks or UART error events (s_tuser). Bytes are
// dropped until a 0x0f header; the next 24 bytes complete a frame, of which bytes 0..23
// go into a 24 x 8 frame RAM. Byte, tick and error items are handled in IDLE as they
// are accepted. The item that completes a frame starts an unpacking pass that reads
// bytes 1..22 from the RAM and shifts eleven-bit channels out of a bit accumulator.
// Each byte passes through a read state and a merge state, each channel through a
// decode state, and each time too few bits are left the decode check sends the
// sequencer back to fetch the next byte; s_tready is low throughout the pass.
// The sixteen channel items carry the flag byte and end with m_tlast.
// A tick that first pushes the silence count past failsafe_limit produces one failsafe
// item (m_tuser = 1, flags 0xff); if the output register is still full it is held
// pending and s_tready drops until it has been loaded. Configuration writes take effect
// at once and are meant for idle periods.
module serial_servo_frame_receiver (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [ssfr_pkg::CFG_W-1:0] cfg_wdata,
    // input items
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] byte_value
    input  logic [1:0]                s_tuser,   // [1:0] mode
    // result items
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                                 // [22:15] flags, [23] zero
    output logic                      m_tuser,   // [0] kind
    output logic                      m_tlast    // last
);
    import ssfr_pkg::*;

    // one-hot sequencer: IDLE takes items, RD issues a RAM read,
    // LD merges the byte into the accumulator, DEC emits channels
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_LD   = 4'b0100,
        ST_DEC  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   bc_reg, bc_next;          // bytes of current frame
    logic [SIL_W-1:0]    sil_reg, sil_next;        // silent ticks
    logic [GAP_W-1:0]    gap_reg;
    logic [SIL_W-1:0]    fs_limit_reg;
    logic                fs_pend_reg, fs_pend_next;

    logic [FLAGS_W-1:0]  flags_reg, flags_next;
    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [NBITS_W-1:0]  nbits_reg, nbits_next;
    logic [IDX_W-1:0]    ch_reg, ch_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [IDX_W-1:0]    m_idx_reg, m_idx_next;
    logic [CHAN_W-1:0]   m_val_reg, m_val_next;
    logic [FLAGS_W-1:0]  m_flags_reg, m_flags_next;
    logic                m_kind_reg, m_kind_next;
    logic                m_last_reg, m_last_next;

    ram_ctl_t            ram_ctl;
    logic [7:0]          rd_data;

    logic                s_acc;
    logic                out_free;
    logic [SIL_W-1:0]    sil_inc;
    mode_t               mode;

    ssfr_frame_ram u_ram (
        .aclk    (aclk),
        .ctl     (ram_ctl),
        .rd_data (rd_data)
    );

    assign mode     = mode_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE) && !fs_pend_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign sil_inc  = (sil_reg == SIL_MAX) ? sil_reg : sil_reg + SIL_W'(1);

    always_comb begin
        state_next    = state_reg;
        bc_next       = bc_reg;
        sil_next      = sil_reg;
        fs_pend_next  = fs_pend_reg;
        flags_next    = flags_reg;
        rd_addr_next  = rd_addr_reg;
        acc_next      = acc_reg;
        nbits_next    = nbits_reg;
        ch_next       = ch_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_idx_next    = m_idx_reg;
        m_val_next    = m_val_reg;
        m_flags_next  = m_flags_reg;
        m_kind_next   = m_kind_reg;
        m_last_next   = m_last_reg;

        ram_ctl.we    = 1'b0;
        ram_ctl.waddr = bc_reg;
        ram_ctl.wdata = s_tdata;
        ram_ctl.raddr = rd_addr_reg;

        case (state_reg)
            ST_IDLE: begin
                // a held-back failsafe notice goes out as soon as the register frees
                if (fs_pend_reg && out_free) begin
                    fs_pend_next  = 1'b0;
                    m_tvalid_next = 1'b1;
                    m_kind_next   = KIND_FAILSAFE;
                    m_idx_next    = '0;
                    m_val_next    = '0;
                    m_flags_next  = FAILSAFE_FLAGS;
                    m_last_next   = 1'b1;
                end
                if (s_acc) begin
                    case (mode)
                        MODE_BYTE: begin
                            sil_next = '0;
                            if (bc_reg != '0 || s_tdata == HEADER_BYTE) begin
                                ram_ctl.we = (bc_reg != LAST_POS);
                                if (bc_reg == FLAGS_POS) begin
                                    flags_next = s_tdata;
                                end
                                if (bc_reg == LAST_POS) begin
                                    // frame complete: start unpacking at byte 1
                                    bc_next      = '0;
                                    rd_addr_next = FIRST_CHAN_POS;
                                    acc_next     = '0;
                                    nbits_next   = '0;
                                    ch_next      = '0;
                                    state_next   = ST_RD;
                                end else begin
                                    bc_next = bc_reg + ADDR_W'(1);
                                end
                            end
                        end
                        MODE_TICK: begin
                            sil_next = sil_inc;
                            if (bc_reg != '0 && sil_inc > SIL_W'(gap_reg)) begin
                                bc_next = '0;
                            end
                            if (sil_reg <= fs_limit_reg && sil_inc > fs_limit_reg) begin
                                if (out_free) begin
                                    m_tvalid_next = 1'b1;
                                    m_kind_next   = KIND_FAILSAFE;
                                    m_idx_next    = '0;
                                    m_val_next    = '0;
                                    m_flags_next  = FAILSAFE_FLAGS;
                                    m_last_next   = 1'b1;
                                end else begin
                                    fs_pend_next = 1'b1;
                                end
                            end
                        end
                        MODE_ERROR: begin
                            bc_next  = '0;
                            sil_next = '0;
                        end
                        default: begin
                            // unused mode code: no effect
                        end
                    endcase
                end
            end
            ST_RD: begin
                state_next = ST_LD;
            end
            ST_LD: begin
                acc_next     = acc_reg | (ACC_W'(rd_data) << nbits_reg);
                nbits_next   = nbits_reg + NBITS_W'(8);
                rd_addr_next = rd_addr_reg + ADDR_W'(1);
                state_next   = ST_DEC;
            end
            ST_DEC: begin
                if (nbits_reg < NBITS_W'(CHAN_W)) begin
                    state_next = ST_RD;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_kind_next   = KIND_CHANNEL;
                    m_idx_next    = ch_reg;
                    m_val_next    = acc_reg[CHAN_W-1:0];
                    m_flags_next  = flags_reg;
                    m_last_next   = (ch_reg == IDX_W'(CHAN_COUNT - 1));
                    acc_next      = acc_reg >> CHAN_W;
                    nbits_next    = nbits_reg - NBITS_W'(CHAN_W);
                    ch_next       = ch_reg + IDX_W'(1);
                    if (ch_reg == IDX_W'(CHAN_COUNT - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bc_reg       <= '0;
            sil_reg      <= '0;
            fs_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            nbits_reg    <= '0;
            ch_reg       <= '0;
            gap_reg      <= GAP_RESET;
            fs_limit_reg <= FAILSAFE_RESET;
        end else begin
            state_reg    <= state_next;
            bc_reg       <= bc_next;
            sil_reg      <= sil_next;
            fs_pend_reg  <= fs_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            nbits_reg    <= nbits_next;
            ch_reg       <= ch_next;
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_GAP_LIMIT:      gap_reg      <= cfg_wdata[GAP_W-1:0];
                    CFG_FAILSAFE_LIMIT: fs_limit_reg <= cfg_wdata[SIL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        flags_reg   <= flags_next;
        rd_addr_reg <= rd_addr_next;
        acc_reg     <= acc_next;
        m_idx_reg   <= m_idx_next;
        m_val_reg   <= m_val_next;
        m_flags_reg <= m_flags_next;
        m_kind_reg  <= m_kind_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_flags_reg, m_val_reg, m_idx_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // frame byte count never passes the end-byte position
    a_bc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bc_reg <= LAST_POS)
        else $error("byte count out of range");

    // accumulator never holds more pending bits than it is wide
    a_nbits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nbits_reg <= NBITS_W'(ACC_W))
        else $error("accumulator overfilled");

    // leaving the unpacking pass always leaves the last channel in the output register
    a_pass_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(state_reg) != ST_IDLE && state_reg == ST_IDLE)
            |-> (m_tvalid_reg && m_last_reg && m_kind_reg == KIND_CHANNEL))
        else $error("unpacking pass ended without last channel");

    // RAM is written only while items are taken, never during unpacking
    a_no_wr_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_ctl.we |-> (state_reg == ST_IDLE && s_acc))
        else $error("frame RAM written outside item acceptance");

endmodule

/* test/ssfr_frame_checker.sv */
// Checker for the serial servo frame receiver: tracks the register writes and both item
// channels, predicts the result items and compares them field by field.
// Depends on ssfr_pkg; instantiated by serial_servo_frame_receiver_tb.
module ssfr_frame_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [ssfr_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] byte_value
    input  logic [1:0]                 s_tuser,   // [1:0] mode
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [23:0]                m_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                                  // [22:15] flags, [23] zero
    input  logic                       m_tuser,   // [0] kind
    input  logic                       m_tlast,
    output int                         mismatch_count,
    output int                         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ssfr_pkg::*;

    localparam int FRAME_LEN = STORE_DEPTH + 1;

    typedef struct {
        kind_t              kind;
        logic [IDX_W-1:0]   index;
        logic [CHAN_W-1:0]  value;
        logic [FLAGS_W-1:0] flags;
        logic               last;
    } servo_item_t;

    servo_item_t        expected_servo_items[$];
    logic [7:0]         frame_bytes[STORE_DEPTH];
    logic [ADDR_W-1:0]  frame_fill;
    logic [SIL_W-1:0]   silence;
    logic [GAP_W-1:0]   gap_limit;
    logic [SIL_W-1:0]   failsafe_limit;

    // Advance the receiver state by one input item and queue what it emits.
    task automatic advance_receiver(logic [1:0] mode, logic [7:0] rx_byte);
        logic [CHAN_COUNT*CHAN_W-1:0] payload;
        logic                         was_quiet;
        case (mode)
            MODE_BYTE: begin
                silence = '0;
                if (frame_fill == 0 && rx_byte != HEADER_BYTE)
                    return;
                if (frame_fill < STORE_DEPTH)
                    frame_bytes[frame_fill] = rx_byte;
                frame_fill++;
                if (frame_fill == FRAME_LEN) begin
                    // bytes 1..22 form one little-endian bit string of 16 x 11 bits
                    for (int i = 0; i < 22; i++)
                        payload[8*i +: 8] = frame_bytes[FIRST_CHAN_POS + i];
                    for (int ch = 0; ch < CHAN_COUNT; ch++)
                        expected_servo_items.push_back('{KIND_CHANNEL, IDX_W'(ch),
                            payload[ch*CHAN_W +: CHAN_W], frame_bytes[FLAGS_POS],
                            ch == CHAN_COUNT - 1});
                    frame_fill = '0;
                end
            end
            MODE_TICK: begin
                was_quiet = silence <= failsafe_limit;
                if (silence != SIL_MAX)
                    silence++;
                if (frame_fill != 0 && silence > gap_limit)
                    frame_fill = '0;
                if (was_quiet && silence > failsafe_limit)
                    expected_servo_items.push_back('{KIND_FAILSAFE, '0, '0,
                        FAILSAFE_FLAGS, 1'b1});
            end
            MODE_ERROR: begin
                frame_fill = '0;
                silence    = '0;
            end
            default: ;  // unused mode: no effect
        endcase
    endtask

    task automatic report_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        servo_item_t want;
        if (!aresetn) begin
            expected_servo_items.delete();
            frame_fill     = '0;
            silence        = '0;
            gap_limit      = GAP_RESET;
            failsafe_limit = FAILSAFE_RESET;
            mismatch_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_GAP_LIMIT:      gap_limit = cfg_wdata[GAP_W-1:0];
                    CFG_FAILSAFE_LIMIT: failsafe_limit = cfg_wdata[SIL_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                advance_receiver(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_servo_items.size() == 0) begin
                    $display({"%0t: unexpected result item, expected none, ",
                              "got kind %0d idx %0d value %0d flags %0d last %0d"},
                             $time, m_tuser, m_tdata[3:0], m_tdata[14:4], m_tdata[22:15],
                             m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_servo_items.pop_front();
                    report_field("kind", want.kind, m_tuser);
                    report_field("channel_index", want.index, m_tdata[3:0]);
                    report_field("channel_value", want.value, m_tdata[14:4]);
                    report_field("flags", want.flags, m_tdata[22:15]);
                    report_field("last", want.last, m_tlast);
                end
            end
        end
        pending_count = expected_servo_items.size();
    end

endmodule

/* test/serial_servo_frame_receiver_tb.sv */
// Testbench top for the serial servo frame receiver: clock, reset, register writes,
// input item stimulus, output back-pressure and the verdict.
// Depends on ssfr_pkg, serial_servo_frame_receiver and ssfr_frame_checker.
module serial_servo_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssfr_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;   // must be ignored by the block
    localparam int         HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int         SETTLE_CYCLES = 16;     // quiet time before register writes
    localparam int         STALL_LIMIT   = 3000;   // cycles with no item moving

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_wr_en;
    logic             cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;    // [7:0] byte_value
    logic [1:0]       s_tuser;    // [1:0] mode
    logic             m_tvalid;
    logic             m_tready;
    logic [23:0]      m_tdata;    // [3:0] channel_index, [14:4] channel_value,
                                  // [22:15] flags, [23] zero
    logic             m_tuser;    // [0] kind
    logic             m_tlast;

    int mismatch_count;
    int pending_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int items_sent;
    int fs_now;       // failsafe limit in force, sizes the tick bursts
    bit hold_req;     // asks the receiver process for one long hold-off
    int stall_cycles;

    always #5 aclk = ~aclk;

    serial_servo_frame_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    ssfr_frame_checker frame_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Offer one item. Called at a falling edge, returns at the falling edge after the
    // item was taken with s_tvalid still high, so back-to-back items need no toggle.
    task automatic push_item(logic [1:0] mode, logic [7:0] rx_byte);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= rx_byte;
        // s_tready read in the active region of the edge: still the pre-edge value
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (mode != MODE_UNUSED)
            items_sent++;
    endtask

    task automatic send_ticks(int count);
        repeat (count) push_item(MODE_TICK, 8'($urandom));
    endtask

    // Drop valid, let every expected result drain, then give the block time to finish
    // any item that produced nothing.
    task automatic drain(int settle);
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    // Both registers, back to back; cfg_wr_en stays high across them.
    task automatic set_limits(logic [GAP_W-1:0] gap, logic [SIL_W-1:0] fs);
        drain(SETTLE_CYCLES);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_GAP_LIMIT;
        cfg_wdata <= CFG_W'(gap);
        @(negedge aclk);
        cfg_addr  <= CFG_FAILSAFE_LIMIT;
        cfg_wdata <= fs;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        fs_now = fs;
    endtask

    // Well-formed frame with random content; now and then a tick slips in between
    // bytes, which breaks the frame when the gap limit is zero.
    task automatic send_frame();
        int         fill;
        logic [7:0] data_byte;
        fill = $urandom_range(9);
        push_item(MODE_BYTE, HEADER_BYTE);
        for (int i = 1; i <= 22; i++) begin
            if ($urandom_range(99) < 2)
                push_item(MODE_TICK, 8'($urandom));
            case (fill)
                0:       data_byte = 8'h00;
                1:       data_byte = 8'hff;
                default: data_byte = 8'($urandom);
            endcase
            push_item(MODE_BYTE, data_byte);
        end
        case ($urandom_range(5))
            0:       push_item(MODE_BYTE, 8'h00);
            1:       push_item(MODE_BYTE, 8'hff);
            default: push_item(MODE_BYTE, 8'($urandom));
        endcase
        push_item(MODE_BYTE, 8'($urandom));   // end byte, never checked
    endtask

    // Noise and broken frames.
    task automatic send_noise();
        int burst_max;
        burst_max = (fs_now + 4 > 40) ? 40 : fs_now + 4;
        case ($urandom_range(4))
            0: push_item(MODE_BYTE, 8'($urandom));
            1: send_ticks($urandom_range(1, burst_max));
            2: push_item(MODE_ERROR, 8'($urandom));
            3: push_item(MODE_UNUSED, 8'($urandom));
            default: begin
                // partial frame followed by an error or by ticks, which cut it short only past the gap limit
                push_item(MODE_BYTE, HEADER_BYTE);
                repeat ($urandom_range(1, 23)) push_item(MODE_BYTE, 8'($urandom));
                if ($urandom_range(1))
                    push_item(MODE_ERROR, 8'($urandom));
                else
                    send_ticks($urandom_range(1, burst_max));
            end
        endcase
    endtask

    task automatic run_traffic(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 65)
                send_frame();
            else
                send_noise();
        end
    endtask

    // Receiver side: random back-pressure, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: any accepted item on either side restarts the count.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = CFG_GAP_LIMIT;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = MODE_BYTE;
        tx_idle_pct  = 35;
        rx_idle_pct  = 53;
        items_sent   = 0;
        fs_now       = FAILSAFE_RESET;
        hold_req     = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: both limits at one, so the second tick past a partial frame both drops
        // it and trips failsafe.
        set_limits(8'd1, 16'd1);
        push_item(MODE_BYTE, 8'h5a);            // no header yet: dropped
        push_item(MODE_UNUSED, HEADER_BYTE);    // unused mode must not start a frame
        push_item(MODE_BYTE, HEADER_BYTE);
        push_item(MODE_BYTE, 8'h12);
        push_item(MODE_TICK, 8'h00);            // silence 1, frame kept
        push_item(MODE_TICK, 8'h00);            // frame dropped, failsafe notice
        push_item(MODE_TICK, 8'h00);            // no second notice
        push_item(MODE_ERROR, 8'h00);
        // channels 0..7 all ones, 8..15 all zeros, flags 0xff
        push_item(MODE_BYTE, HEADER_BYTE);
        repeat (11) push_item(MODE_BYTE, 8'hff);
        repeat (11) push_item(MODE_BYTE, 8'h00);
        push_item(MODE_BYTE, 8'hff);
        push_item(MODE_BYTE, 8'h00);

        // Phase A: largest gap limit, sender idles 35%, receiver 53%.
        set_limits(8'd255, 16'd20);
        run_traffic(110);

        // Phase B: gap limit zero, any tick kills a partial frame; idling swapped.
        tx_idle_pct = 53;
        rx_idle_pct = 35;
        set_limits(8'd0, 16'd5);
        run_traffic(110);

        // Phase C: no idling. Start with a long receiver hold-off while whole frames
        // keep coming, so the output stalls and s_tready drops.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_limits(8'd3, 16'd65534);
        hold_req = 1'b1;
        repeat (3) send_frame();
        run_traffic(60);
        // Highest failsafe limit: the silence can never pass it, so never a notice.
        set_limits(8'd3, 16'hffff);
        send_ticks(20);
        send_frame();

        drain(100);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
rtl/ssfr_pkg.sv
rtl/ssfr_frame_ram.sv
rtl/serial_servo_frame_receiver.sv
test/ssfr_frame_checker.sv
test/serial_servo_frame_receiver_tb.sv
